// ===== src/sphere_region_id_tagger_macros.svh =====
// ----------------------------------------------------------------------------
// Sphere region id tagger: assertion macros
// Short forms for the concurrent checks used in the back end.
// ----------------------------------------------------------------------------
`ifndef SPHERE_REGION_ID_TAGGER_MACROS_SVH
`define SPHERE_REGION_ID_TAGGER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srit: next-cycle check failed");

`endif

// ===== src/srit_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere region id tagger: shared package
// Sizes, item and table entry types, and the id tagging function.
// ----------------------------------------------------------------------------
package srit_pkg;

    localparam int NUM_SLOTS     = 16;
    localparam int TAG_START_BIT = 56;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int GROUP_W  = 8;
    localparam int ID_W     = 64;
    localparam int SLOT_IN_W = 4;
    localparam int CFG_W    = 5;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = (SLOT_W + 1 > CFG_W) ? SLOT_W + 1 : CFG_W;

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 64;

    localparam int FIFO_DEPTH = 2;

    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    localparam logic [ID_W-1:0] ID_LOW_MASK = ~({ID_W{1'b1}} << TAG_START_BIT);

    typedef struct packed {
        logic                      action;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [RADIUS_W-1:0]       radius;
        logic [GROUP_W-1:0]        group;
        logic [ID_W-1:0]           particle_id;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RADIUS_W-1:0]       radius;
        logic [GROUP_W-1:0]        group;
    } sphere_t;

    // Clear the tag bits and put group plus one there; bits above the id drop off.
    function automatic logic [ID_W-1:0] tag_id(input logic [ID_W-1:0] id,
                                               input logic [GROUP_W-1:0] grp);
        logic [GROUP_W:0] tag;
        logic [ID_W-1:0]  tag_sh;
        tag    = {1'b0, grp} + 1'b1;
        tag_sh = ID_W'(tag) << TAG_START_BIT;
        return (id & ID_LOW_MASK) | tag_sh;
    endfunction

endpackage

// ===== src/srit_front.sv =====
// ----------------------------------------------------------------------------
// Sphere region id tagger: front end
// Unpacks input beats, sorts loads from particles and drops loads to
// slots that do not exist.
// ----------------------------------------------------------------------------
module srit_front (
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [srit_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output srit_pkg::item_t                      push_item
);

    localparam int OFF_SLOT = 0;
    localparam int OFF_X    = OFF_SLOT + srit_pkg::SLOT_IN_W;
    localparam int OFF_Y    = OFF_X + srit_pkg::COORD_W;
    localparam int OFF_Z    = OFF_Y + srit_pkg::COORD_W;
    localparam int OFF_R    = OFF_Z + srit_pkg::COORD_W;
    localparam int OFF_G    = OFF_R + srit_pkg::RADIUS_W;
    localparam int OFF_ID   = OFF_G + srit_pkg::GROUP_W;

    logic [srit_pkg::SLOT_IN_W-1:0] slot_in;
    logic                           slot_ok;
    logic                           is_classify;

    assign slot_in     = s_axis_tdata[OFF_SLOT +: srit_pkg::SLOT_IN_W];
    assign slot_ok     = (int'(slot_in) < srit_pkg::NUM_SLOTS);
    assign is_classify = (s_axis_tuser[0] == srit_pkg::ACT_CLASSIFY);

    always_comb
    begin
        push_item.action      = s_axis_tuser[0];
        push_item.slot        = srit_pkg::SLOT_W'(slot_in);
        push_item.pos_x       = s_axis_tdata[OFF_X +: srit_pkg::COORD_W];
        push_item.pos_y       = s_axis_tdata[OFF_Y +: srit_pkg::COORD_W];
        push_item.pos_z       = s_axis_tdata[OFF_Z +: srit_pkg::COORD_W];
        push_item.radius      = s_axis_tdata[OFF_R +: srit_pkg::RADIUS_W];
        push_item.group       = s_axis_tdata[OFF_G +: srit_pkg::GROUP_W];
        push_item.particle_id = s_axis_tdata[OFF_ID +: srit_pkg::ID_W];
    end

    // Take a load to a missing slot but drop it here.
    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid && (is_classify || slot_ok);

endmodule

// ===== src/srit_fifo.sv =====
// ----------------------------------------------------------------------------
// Sphere region id tagger: item queue
// Short queue between front and back end so either can stall alone.
// ----------------------------------------------------------------------------
module srit_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  srit_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output srit_pkg::item_t pop_item
);

    localparam int PTR_W = (srit_pkg::FIFO_DEPTH > 1) ? $clog2(srit_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(srit_pkg::FIFO_DEPTH + 1);

    srit_pkg::item_t  entries_reg [srit_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(srit_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(srit_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(srit_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/srit_back.sv =====
// ----------------------------------------------------------------------------
// Sphere region id tagger: back end
// Holds the sphere table, runs one slot per cycle through the distance
// pipeline, tags the id and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "sphere_region_id_tagger_macros.svh"

module srit_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [srit_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  srit_pkg::item_t                  pop_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [srit_pkg::ID_W-1:0]        out_id,
    output logic                             out_matched
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam int CNT_W = srit_pkg::CNT_W;
    localparam int CW    = srit_pkg::COORD_W;
    localparam int RW    = srit_pkg::RADIUS_W;
    localparam int GW    = srit_pkg::GROUP_W;
    localparam int IW    = srit_pkg::ID_W;

    srit_pkg::sphere_t mem [srit_pkg::NUM_SLOTS];

    logic [1:0]                 state_reg, state_next;
    logic [srit_pkg::CFG_W-1:0] spheres_in_use_reg;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           n_w;

    logic signed [CW-1:0]       px_reg, py_reg, pz_reg;
    logic [IW-1:0]              id_acc_reg, id_acc_next;
    logic                       hit_acc_reg, hit_acc_next;

    logic                       p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    srit_pkg::sphere_t          rd_q_reg;
    logic signed [CW:0]         dx_reg, dy_reg, dz_reg;
    logic [RW-1:0]              p2_r_reg;
    logic [GW-1:0]              p2_group_reg, p3_group_reg, p4_group_reg;
    logic [2*CW-1:0]            sqx_reg, sqy_reg, sqz_reg;
    logic [2*RW-1:0]            rr_reg, p4_rr_reg;
    logic [2*CW+1:0]            dist_reg;

    logic signed [2*CW+1:0]     prod_x, prod_y, prod_z;
    logic [2*RW-1:0]            rr_w;

    logic                       out_valid_reg, out_valid_next;
    logic [IW-1:0]              out_id_reg;
    logic                       out_matched_reg;

    logic                       do_pop, start_job, mem_we, issue, out_load;
    logic                       pipe_busy, hit4;

    assign n_w = (CNT_W'(spheres_in_use_reg) > CNT_W'(srit_pkg::NUM_SLOTS))
               ? CNT_W'(srit_pkg::NUM_SLOTS) : CNT_W'(spheres_in_use_reg);

    assign pop_ready = (state_reg == ST_IDLE);
    assign do_pop    = pop_valid && pop_ready;
    assign pipe_busy = p1_valid_reg || p2_valid_reg || p3_valid_reg || p4_valid_reg;
    assign hit4      = p4_valid_reg && (dist_reg < (2*CW+2)'(p4_rr_reg));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        start_job      = 1'b0;
        mem_we         = 1'b0;
        issue          = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (do_pop)
                begin
                    if (pop_item.action == srit_pkg::ACT_CLASSIFY)
                    begin
                        start_job  = 1'b1;
                        cnt_next   = '0;
                        state_next = (n_w == '0) ? ST_DRAIN : ST_RUN;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                issue    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == n_w - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // Wait for the last slot to leave the pipe and the output to free up.
                if (!pipe_busy && (!out_valid_reg || out_ready))
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        id_acc_next  = id_acc_reg;
        hit_acc_next = hit_acc_reg;
        if (start_job)
        begin
            id_acc_next  = pop_item.particle_id;
            hit_acc_next = 1'b0;
        end
        else if (hit4)
        begin
            id_acc_next  = srit_pkg::tag_id(id_acc_reg, p4_group_reg);
            hit_acc_next = 1'b1;
        end
    end

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign prod_z = dz_reg * dz_reg;
    assign rr_w   = {{RW{1'b0}}, p2_r_reg} * {{RW{1'b0}}, p2_r_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            spheres_in_use_reg <= '0;
            cnt_reg            <= '0;
            hit_acc_reg        <= 1'b0;
            p1_valid_reg       <= 1'b0;
            p2_valid_reg       <= 1'b0;
            p3_valid_reg       <= 1'b0;
            p4_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                spheres_in_use_reg <= cfg_wr_data;
            end
            cnt_reg       <= cnt_next;
            hit_acc_reg   <= hit_acc_next;
            p1_valid_reg  <= issue;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sphere table: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pop_item.slot] <= '{cx: pop_item.pos_x, cy: pop_item.pos_y,
                                    cz: pop_item.pos_z, radius: pop_item.radius,
                                    group: pop_item.group};
        end
        rd_q_reg <= mem[cnt_reg[srit_pkg::SLOT_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (start_job)
        begin
            px_reg <= pop_item.pos_x;
            py_reg <= pop_item.pos_y;
            pz_reg <= pop_item.pos_z;
        end
        id_acc_reg <= id_acc_next;

        dx_reg       <= (CW+1)'(px_reg) - (CW+1)'(rd_q_reg.cx);
        dy_reg       <= (CW+1)'(py_reg) - (CW+1)'(rd_q_reg.cy);
        dz_reg       <= (CW+1)'(pz_reg) - (CW+1)'(rd_q_reg.cz);
        p2_r_reg     <= rd_q_reg.radius;
        p2_group_reg <= rd_q_reg.group;

        // A difference squared stays below 2^64, so the low bits carry it.
        sqx_reg      <= prod_x[2*CW-1:0];
        sqy_reg      <= prod_y[2*CW-1:0];
        sqz_reg      <= prod_z[2*CW-1:0];
        rr_reg       <= rr_w;
        p3_group_reg <= p2_group_reg;

        dist_reg     <= (2*CW+2)'(sqx_reg) + (2*CW+2)'(sqy_reg) + (2*CW+2)'(sqz_reg);
        p4_rr_reg    <= rr_reg;
        p4_group_reg <= p3_group_reg;

        if (out_load)
        begin
            out_id_reg      <= id_acc_reg;
            out_matched_reg <= hit_acc_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_id      = out_id_reg;
    assign out_matched = out_matched_reg;

    `SRIT_ASSERT_NOW(a_idle_pipe_empty, clk, rst_n, state_reg == ST_IDLE, !pipe_busy)
    `SRIT_ASSERT_NOW(a_run_cnt_range, clk, rst_n, state_reg == ST_RUN, cnt_reg < n_w)
    `SRIT_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, mem_we, state_reg == ST_IDLE)

endmodule

// ===== src/sphere_region_id_tagger.sv =====
// ----------------------------------------------------------------------------
// Sphere region id tagger: top level
// Tags particle ids by the highest tested slot whose sphere contains the particle.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) writes one sphere slot and gives no output; a load to
// a slot beyond the table is dropped. A particle beat (tuser 1) is tested
// against slots 0 to spheres_in_use-1 (capped at 16) and gives one output
// beat. Load beats occupy the back end for one cycle; a particle beat holds
// it until its result is loaded into the output register, and runs no slot
// when the capped sphere count is zero. Its steps are the pop, the single
// shared distance-and-compare pipeline of four stages that tests one slot
// per cycle, and the output load. A two-entry queue lets the input
// keep accepting while a result waits at the output. Slots must be loaded
// before they are tested: the table is not cleared at reset. Write
// spheres_in_use only while the block is idle.
module sphere_region_id_tagger (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [srit_pkg::CFG_W-1:0]          cfg_wr_data,      // spheres_in_use
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // slot, pos_x, pos_y, pos_z, radius, group, particle_id, zero pad
    input  logic [srit_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [0:0]                          s_axis_tuser,     // action
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [srit_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,     // tagged_id
    output logic [0:0]                          m_axis_tuser      // matched
);

    logic            push_valid, push_ready;
    srit_pkg::item_t push_item;
    logic            pop_valid, pop_ready;
    srit_pkg::item_t pop_item;
    logic            out_matched;

    srit_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    srit_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    srit_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_id      (m_axis_tdata),
        .out_matched (out_matched)
    );

    assign m_axis_tuser = out_matched;

endmodule

// ===== sim/sphere_region_id_tagger_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere region id tagger: testbench
// Streams sphere loads and particle beats into the tagger and compares every
// output beat with a local model. The local model keeps the sphere table and
// the sphere count, and tests each particle against the spheres. Each
// particle is tested at full distance width, and the last sphere that
// contains it sets the tag. The run covers a directed set of corner points,
// then random phases at several sphere counts, most with idling on both sides.
// ----------------------------------------------------------------------------
module sphere_region_id_tagger_tb;
    import srit_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0] tagged_id;
        logic            matched;
    } tag_result_t;

    localparam int IDLE_PCT       = 8;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_BEATS    = 172;
    localparam int NUM_PHASES     = 9;
    localparam int REPORT_LIMIT   = 10;

    // tdata field offsets
    localparam int OFF_X  = SLOT_IN_W;
    localparam int OFF_Y  = OFF_X + COORD_W;
    localparam int OFF_Z  = OFF_Y + COORD_W;
    localparam int OFF_R  = OFF_Z + COORD_W;
    localparam int OFF_G  = OFF_R + RADIUS_W;
    localparam int OFF_ID = OFF_G + GROUP_W;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic [RADIUS_W-1:0]       RADIUS_MAX = 31'h7FFF_FFFF;
    localparam logic [RADIUS_W-1:0]       UNIT_RADIUS = 31'h0001_0000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    item_t       beat_queue[$];
    item_t       cur_beat;
    tag_result_t tag_expect[$];
    logic        in_fire = 1'b0;
    bit          steady = 1'b0;
    int          fail_count = 0;
    int          sphere_count = 0;

    // sphere table as the block holds it
    logic signed [COORD_W-1:0] sph_cx [NUM_SLOTS];
    logic signed [COORD_W-1:0] sph_cy [NUM_SLOTS];
    logic signed [COORD_W-1:0] sph_cz [NUM_SLOTS];
    logic [RADIUS_W-1:0]       sph_r  [NUM_SLOTS];
    logic [GROUP_W-1:0]        sph_grp[NUM_SLOTS];

    // sphere table as queued, used to aim particles at spheres
    logic signed [COORD_W-1:0] aim_cx [NUM_SLOTS];
    logic signed [COORD_W-1:0] aim_cy [NUM_SLOTS];
    logic signed [COORD_W-1:0] aim_cz [NUM_SLOTS];
    logic [RADIUS_W-1:0]       aim_r  [NUM_SLOTS];

    sphere_region_id_tagger i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic logic [65:0] axis_sq(input logic signed [COORD_W-1:0] a,
                                            input logic signed [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (d[COORD_W])
        begin
            d = -d;
        end
        return 66'(d) * 66'(d);
    endfunction

    function automatic tag_result_t classify_particle(input item_t b);
        tag_result_t    res;
        logic [65:0]    dist_sq;
        logic [GROUP_W:0] tag;
        int             s;
        res.tagged_id = b.particle_id;
        res.matched   = 1'b0;
        for (s = 0; s < sphere_count; s++)
        begin
            dist_sq = axis_sq(b.pos_x, sph_cx[s]) + axis_sq(b.pos_y, sph_cy[s])
                    + axis_sq(b.pos_z, sph_cz[s]);
            if (dist_sq < 66'(sph_r[s]) * 66'(sph_r[s]))
            begin
                // later spheres overwrite the tag of earlier ones
                tag = {1'b0, sph_grp[s]} + 1'b1;
                res.tagged_id = (res.tagged_id & ((64'd1 << TAG_START_BIT) - 64'd1))
                              | (64'(tag) << TAG_START_BIT);
                res.matched = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic take_beat(input item_t b);
        if (b.action == ACT_LOAD)
        begin
            if (int'(b.slot) < NUM_SLOTS)
            begin
                sph_cx[b.slot]  = b.pos_x;
                sph_cy[b.slot]  = b.pos_y;
                sph_cz[b.slot]  = b.pos_z;
                sph_r[b.slot]   = b.radius;
                sph_grp[b.slot] = b.group;
            end
        end
        else
        begin
            tag_expect.push_back(classify_particle(b));
        end
    endtask

    task automatic note_fail(input string what, input logic [ID_W-1:0] exp_v,
                             input logic [ID_W-1:0] act_v);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("mismatch: %s expected %h actual %h", what, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver and monitors
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || in_fire)
        begin
            if (beat_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                cur_beat = beat_queue.pop_front();
                s_axis_tdata  <= {{(IN_TDATA_W - OFF_ID - ID_W){1'b0}}, cur_beat.particle_id,
                                  cur_beat.group, cur_beat.radius, cur_beat.pos_z,
                                  cur_beat.pos_y, cur_beat.pos_x, cur_beat.slot};
                s_axis_tuser  <= cur_beat.action;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            take_beat(cur_beat);
        end
    end

    always @(posedge clk)
    begin
        tag_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tag_expect.size() == 0)
            begin
                note_fail("output beat with none pending, tagged_id", '0, m_axis_tdata);
            end
            else
            begin
                exp_r = tag_expect.pop_front();
                if (m_axis_tdata !== exp_r.tagged_id)
                begin
                    note_fail("tagged_id", exp_r.tagged_id, m_axis_tdata);
                end
                if (m_axis_tuser[0] !== exp_r.matched)
                begin
                    note_fail("matched", ID_W'(exp_r.matched), ID_W'(m_axis_tuser[0]));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return COORD_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    endfunction

    function automatic logic [RADIUS_W-1:0] rand_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            return '0;
        end
        if (roll < 20)
        begin
            return RADIUS_W'($urandom_range(0, 32'h7FFF_FFFF));
        end
        return RADIUS_W'($urandom_range(1 << 14, 1 << 23));
    endfunction

    // Offset of up to five eighths of the radius per axis: mostly inside.
    function automatic logic signed [COORD_W-1:0] near_coord(
        input logic signed [COORD_W-1:0] c, input logic [RADIUS_W-1:0] r);
        longint span;
        longint off;
        span = (longint'(r) >> 1) + (longint'(r) >> 3);
        off  = longint'($urandom_range(0, 32'(2 * span))) - span;
        return COORD_W'(longint'(c) + off);
    endfunction

    task automatic queue_load(input int slot, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z,
                              input logic [RADIUS_W-1:0] r, input logic [GROUP_W-1:0] g);
        item_t b;
        b = '0;
        b.action = ACT_LOAD;
        b.slot   = SLOT_W'(slot);
        b.pos_x  = x;
        b.pos_y  = y;
        b.pos_z  = z;
        b.radius = r;
        b.group  = g;
        // random noise in the fields a load does not use
        b.particle_id = {$urandom, $urandom};
        beat_queue.push_back(b);
        aim_cx[slot] = x;
        aim_cy[slot] = y;
        aim_cz[slot] = z;
        aim_r[slot]  = r;
    endtask

    task automatic queue_particle(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y,
                                  input logic signed [COORD_W-1:0] z,
                                  input logic [ID_W-1:0] id);
        item_t b;
        b = '0;
        b.action      = ACT_CLASSIFY;
        b.slot        = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        b.pos_x       = x;
        b.pos_y       = y;
        b.pos_z       = z;
        b.radius      = RADIUS_W'($urandom_range(0, 32'h7FFF_FFFF));
        b.group       = GROUP_W'($urandom_range(0, 254));
        b.particle_id = id;
        beat_queue.push_back(b);
    endtask

    task automatic queue_random_beat();
        int roll;
        int s;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            queue_load($urandom_range(0, NUM_SLOTS - 1), rand_coord(), rand_coord(),
                       rand_coord(), rand_radius(), GROUP_W'($urandom_range(0, 254)));
        end
        else if (sphere_count > 0 && roll < 75)
        begin
            s = $urandom_range(0, sphere_count - 1);
            queue_particle(near_coord(aim_cx[s], aim_r[s]), near_coord(aim_cy[s], aim_r[s]),
                           near_coord(aim_cz[s], aim_r[s]), {$urandom, $urandom});
        end
        else
        begin
            queue_particle(rand_coord(), rand_coord(), rand_coord(), {$urandom, $urandom});
        end
    endtask

    task automatic set_sphere_count(input int v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(v);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sphere_count = (v > NUM_SLOTS) ? NUM_SLOTS : v;
    endtask

    // Wait until every beat is sent and every result is out, then let the back end settle.
    task automatic drain();
        while (beat_queue.size() != 0 || s_axis_tvalid || tag_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase_count[NUM_PHASES];
        int p;
        int s;
        phase_count = '{16, 1, 31, 0, 5, 12, 17, 16, 0};
        phase_count[NUM_PHASES - 1] = int'($urandom_range(0, 31));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no spheres tested: ids pass unchanged
        set_sphere_count(0);
        queue_particle(COORD_MAX, COORD_MIN, COORD_MAX, '1);
        queue_particle('0, '0, '0, '0);

        // fill the whole table before any sphere is tested
        queue_load(0, '0, '0, '0, UNIT_RADIUS, 8'd0);
        queue_load(1, COORD_MIN, COORD_MAX, COORD_MIN, RADIUS_MAX, 8'd254);
        queue_load(2, 32'sd1000, 32'sd1000, 32'sd1000, '0, 8'h55);
        queue_load(3, '0, '0, '0, 31'h0010_0000, 8'hAA);
        for (s = 4; s < NUM_SLOTS; s++)
        begin
            queue_load(s, COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                       COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                       COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                       RADIUS_W'($urandom_range(1 << 16, 1 << 21)),
                       GROUP_W'($urandom_range(0, 254)));
        end
        drain();

        // count above the table size caps at the table size
        set_sphere_count(31);
        queue_particle('0, '0, '0, '1);
        // exactly on the surface of the unit sphere: not inside
        queue_particle(32'sh0001_0000, '0, '0, '0);
        // opposite corner: the squared distance must not wrap
        queue_particle(COORD_MAX, COORD_MIN, COORD_MAX, {$urandom, $urandom});
        // centre of the widest sphere with the top group
        queue_particle(COORD_MIN, COORD_MAX, COORD_MIN, {$urandom, $urandom});
        queue_particle(COORD_MIN + 32'sh4000_0000, COORD_MAX, COORD_MIN, '1);
        // zero radius never contains its own centre
        queue_particle(32'sd1000, 32'sd1000, 32'sd1000, {$urandom, $urandom});
        drain();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_sphere_count(phase_count[p]);
            steady = (p == 2);
            repeat (PHASE_BEATS) queue_random_beat();
            drain();
        end
        steady = 1'b0;

        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/srit_pkg.sv
src/srit_front.sv
src/srit_fifo.sv
src/srit_back.sv
src/sphere_region_id_tagger.sv
sim/sphere_region_id_tagger_tb.sv
